### rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/b26_pkg.sv
// package: types, constants and power table of the base-26 converter
`default_nettype none

package b26_pkg;

  localparam int unsigned NUM_W           = 62;
  localparam int unsigned LET_W           = 5;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned DIG_BITS        = 5;
  localparam int unsigned SH_W            = 3;
  localparam int unsigned WIDE_W          = NUM_W + DIG_BITS - 1;
  localparam int unsigned MAX_LETTERS_DEF = 13;
  localparam int unsigned POW_DEPTH       = 14;

  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [LET_W-1:0]  let_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SH_W-1:0]   sh_t;
  typedef logic [WIDE_W-1:0] wide_t;

  localparam let_t LET_Z  = let_t'(25);
  localparam sh_t  SH_TOP = sh_t'(DIG_BITS - 1);

  localparam logic CMD_NUMBER  = 1'b0;
  localparam logic CMD_LETTER  = 1'b1;
  localparam logic KIND_LETTER = 1'b0;
  localparam logic KIND_NUMBER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_DIG,
    ST_EMIT_LET,
    ST_EMIT_NUM,
    ST_EMIT_EMPTY
  } st_e;

  // result of the shared compare-subtract unit
  typedef struct packed {
    logic ge;
    num_t diff;
  } sub_res_t;

  typedef num_t pow_tab_t [POW_DEPTH];

  function automatic pow_tab_t pow26_tab();
    pow_tab_t t;
    t[0] = num_t'(1);
    for (int i = 1; i < POW_DEPTH; i++) begin
      t[i] = num_t'(t[i-1] * num_t'(26));
    end
    return t;
  endfunction

  localparam pow_tab_t POW26 = pow26_tab();

  // largest value that m letters can spell: m Z's
  function automatic num_t max_value(int unsigned m);
    num_t s;
    s = '0;
    for (int unsigned i = 1; i <= m; i++) begin
      s = s + POW26[i];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/b26_if.sv
// handshake interfaces for input words and result words
`default_nettype none

interface b26_in_if;
  logic             valid;
  logic             ready;
  logic             command;
  b26_pkg::num_t    number;
  b26_pkg::let_t    letter;
  logic             final_letter;

  modport source (output valid, command, number, letter, final_letter, input ready);
  modport sink   (input valid, command, number, letter, final_letter, output ready);
endinterface

interface b26_out_if;
  logic             valid;
  logic             ready;
  logic             kind;
  b26_pkg::let_t    out_letter;
  logic             empty_res;
  b26_pkg::num_t    out_number;
  logic             overflow;
  logic             last;

  modport source (output valid, kind, out_letter, empty_res, out_number, overflow, last,
                  input ready);
  modport sink   (input valid, kind, out_letter, empty_res, out_number, overflow, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/b26_sub_unit.sv
// shared compare-subtract unit: a against p shifted left by sh
`default_nettype none

module b26_sub_unit (
  input  b26_pkg::num_t     a_i,
  input  b26_pkg::num_t     p_i,
  input  b26_pkg::sh_t      sh_i,
  output b26_pkg::sub_res_t res_o
);

  b26_pkg::wide_t a_wide;
  b26_pkg::wide_t b_wide;

  assign a_wide = b26_pkg::wide_t'(a_i);
  assign b_wide = b26_pkg::wide_t'(p_i) << sh_i;

  assign res_o.ge   = (a_wide >= b_wide);
  // only meaningful when ge is set, then b fits in the number width
  assign res_o.diff = a_i - b_wide[b26_pkg::NUM_W-1:0];

endmodule

`default_nettype wire

### rtl/bijective_base26_converter_unit.sv
// top level: bijective base-26 number/letter converter
// letter word: taken while idle; a final letter's number goes via ST_EMIT_NUM to the output
// number word of n letters: a power search in ST_LEN, then per letter 5 restoring steps in
//   ST_DIG and an emit in ST_EMIT_LET; search and steps share the one subtractor
// no new word during a number conversion; non-final letters stream one per cycle, a final one
//   holds the input in ST_EMIT_NUM until its result is loaded
// reset (async, active low) clears the sequencer state, the output valid and the string state
`default_nettype none

module bijective_base26_converter_unit #(
  parameter int unsigned MAX_LETTERS = b26_pkg::MAX_LETTERS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  b26_in_if.sink      in_i,
  b26_out_if.source   out_o
);

  localparam b26_pkg::num_t MaxVal = b26_pkg::max_value(MAX_LETTERS);
  localparam b26_pkg::cnt_t MaxCnt = b26_pkg::cnt_t'(MAX_LETTERS);

  b26_pkg::st_e     st_q, st_d;
  b26_pkg::cnt_t    k_q, k_d;
  b26_pkg::sh_t     sh_q, sh_d;
  b26_pkg::let_t    dig_q, dig_d;
  b26_pkg::num_t    n_q, n_d;
  logic             ovf_q, ovf_d;
  b26_pkg::num_t    acc_q, acc_d;
  b26_pkg::cnt_t    cnt_q, cnt_d;
  logic             long_q, long_d;

  logic             ov_q, ov_d;
  logic             o_kind_q, o_kind_d;
  b26_pkg::let_t    o_let_q, o_let_d;
  logic             o_empty_q, o_empty_d;
  b26_pkg::num_t    o_num_q, o_num_d;
  logic             o_ovf_q, o_ovf_d;
  logic             o_last_q, o_last_d;

  logic             in_acc;
  logic             slot_free;
  logic             cnt_full;
  b26_pkg::let_t    let_sat;
  b26_pkg::num_t    acc_next;
  b26_pkg::sh_t     unit_sh;
  b26_pkg::sub_res_t sr;

  assign in_i.ready = (st_q == b26_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !ov_q || out_o.ready;
  assign cnt_full   = (cnt_q >= MaxCnt);
  assign let_sat    = (in_i.letter > b26_pkg::LET_Z) ? b26_pkg::LET_Z : in_i.letter;
  // acc*26 as shifts and adds
  assign acc_next   = (acc_q << 4) + (acc_q << 3) + (acc_q << 1)
                    + b26_pkg::num_t'(let_sat) + b26_pkg::num_t'(1);

  assign unit_sh = (st_q == b26_pkg::ST_DIG) ? sh_q : '0;

  b26_sub_unit u_sub (
    .a_i   (n_q),
    .p_i   (b26_pkg::POW26[k_q]),
    .sh_i  (unit_sh),
    .res_o (sr)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      b26_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.command == b26_pkg::CMD_NUMBER) begin
            st_d = (in_i.number == '0) ? b26_pkg::ST_EMIT_EMPTY : b26_pkg::ST_LEN;
          end else if (in_i.final_letter) begin
            st_d = b26_pkg::ST_EMIT_NUM;
          end
        end
      end
      b26_pkg::ST_LEN: begin
        if (k_q == MaxCnt || !sr.ge) begin
          st_d = b26_pkg::ST_DIG;
        end
      end
      b26_pkg::ST_DIG: begin
        if (sh_q == '0) begin
          st_d = b26_pkg::ST_EMIT_LET;
        end
      end
      b26_pkg::ST_EMIT_LET: begin
        if (slot_free) begin
          st_d = (k_q == '0) ? b26_pkg::ST_IDLE : b26_pkg::ST_DIG;
        end
      end
      b26_pkg::ST_EMIT_NUM, b26_pkg::ST_EMIT_EMPTY: begin
        if (slot_free) begin
          st_d = b26_pkg::ST_IDLE;
        end
      end
      default: st_d = b26_pkg::ST_IDLE;
    endcase
  end

  // sequencer datapath and string state
  always_comb begin
    k_d    = k_q;
    sh_d   = sh_q;
    dig_d  = dig_q;
    n_d    = n_q;
    ovf_d  = ovf_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    long_d = long_q;
    unique case (st_q)
      b26_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.command == b26_pkg::CMD_NUMBER) begin
            ovf_d = (in_i.number > MaxVal);
            n_d   = ovf_d ? MaxVal : in_i.number;
            k_d   = '0;
          end else begin
            if (cnt_full) begin
              long_d = 1'b1;
            end else begin
              acc_d = acc_next;
              cnt_d = cnt_q + b26_pkg::cnt_t'(1);
            end
            if (in_i.final_letter) begin
              ovf_d  = long_d;
              n_d    = long_d ? '0 : acc_d;
              acc_d  = '0;
              cnt_d  = '0;
              long_d = 1'b0;
            end
          end
        end
      end
      b26_pkg::ST_LEN: begin
        if (k_q == MaxCnt || !sr.ge) begin
          // k now holds the letter count; step to the top digit's power
          k_d   = k_q - b26_pkg::cnt_t'(1);
          sh_d  = b26_pkg::SH_TOP;
          dig_d = '0;
        end else begin
          n_d = sr.diff;
          k_d = k_q + b26_pkg::cnt_t'(1);
        end
      end
      b26_pkg::ST_DIG: begin
        if (sr.ge) begin
          n_d   = sr.diff;
          dig_d = dig_q | (b26_pkg::let_t'(1) << sh_q);
        end
        if (sh_q != '0) begin
          sh_d = sh_q - b26_pkg::sh_t'(1);
        end
      end
      b26_pkg::ST_EMIT_LET: begin
        if (slot_free && k_q != '0) begin
          k_d   = k_q - b26_pkg::cnt_t'(1);
          sh_d  = b26_pkg::SH_TOP;
          dig_d = '0;
        end
      end
      b26_pkg::ST_EMIT_NUM, b26_pkg::ST_EMIT_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    ov_d      = ov_q && !out_o.ready;
    o_kind_d  = o_kind_q;
    o_let_d   = o_let_q;
    o_empty_d = o_empty_q;
    o_num_d   = o_num_q;
    o_ovf_d   = o_ovf_q;
    o_last_d  = o_last_q;
    if (slot_free) begin
      unique case (st_q)
        b26_pkg::ST_EMIT_LET: begin
          ov_d      = 1'b1;
          o_kind_d  = b26_pkg::KIND_LETTER;
          o_let_d   = (dig_q > b26_pkg::LET_Z) ? b26_pkg::LET_Z : dig_q;
          o_empty_d = 1'b0;
          o_num_d   = '0;
          o_ovf_d   = ovf_q;
          o_last_d  = (k_q == '0);
        end
        b26_pkg::ST_EMIT_NUM: begin
          ov_d      = 1'b1;
          o_kind_d  = b26_pkg::KIND_NUMBER;
          o_let_d   = '0;
          o_empty_d = 1'b0;
          o_num_d   = n_q;
          o_ovf_d   = ovf_q;
          o_last_d  = 1'b1;
        end
        b26_pkg::ST_EMIT_EMPTY: begin
          ov_d      = 1'b1;
          o_kind_d  = b26_pkg::KIND_LETTER;
          o_let_d   = '0;
          o_empty_d = 1'b1;
          o_num_d   = '0;
          o_ovf_d   = 1'b0;
          o_last_d  = 1'b1;
        end
        b26_pkg::ST_IDLE, b26_pkg::ST_LEN, b26_pkg::ST_DIG: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= b26_pkg::ST_IDLE;
      ov_q   <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
      long_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ov_q   <= ov_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      long_q <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    sh_q      <= sh_d;
    dig_q     <= dig_d;
    n_q       <= n_d;
    ovf_q     <= ovf_d;
    o_kind_q  <= o_kind_d;
    o_let_q   <= o_let_d;
    o_empty_q <= o_empty_d;
    o_num_q   <= o_num_d;
    o_ovf_q   <= o_ovf_d;
    o_last_q  <= o_last_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = o_kind_q;
  assign out_o.out_letter = o_let_q;
  assign out_o.empty_res  = o_empty_q;
  assign out_o.out_number = o_num_q;
  assign out_o.overflow   = o_ovf_q;
  assign out_o.last       = o_last_q;

endmodule

`default_nettype wire

### rtl/b26_checker.sv
// port-level checker for the base-26 converter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module b26_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_i,
  input wire           in_command_i,
  input wire           in_final_i,
  input wire           out_valid_i,
  input wire           out_ready_i,
  input wire           out_kind_i,
  input b26_pkg::let_t out_letter_i,
  input wire           out_empty_i,
  input b26_pkg::num_t out_number_i,
  input wire           out_overflow_i,
  input wire           out_last_i
);

  logic                                          out_stall;
  logic [b26_pkg::NUM_W+b26_pkg::LET_W+3:0]      out_word;
  logic                                          empty_ok;
  logic                                          num_ovf;
  logic                                          mid_letter;

  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_word   = {out_kind_i, out_letter_i, out_empty_i, out_number_i,
                       out_overflow_i, out_last_i};
  assign empty_ok   = out_last_i && out_kind_i == b26_pkg::KIND_LETTER && out_letter_i == '0;
  assign num_ovf    = out_valid_i && out_kind_i == b26_pkg::KIND_NUMBER && out_overflow_i;
  assign mid_letter = in_valid_i && in_ready_i && in_command_i == b26_pkg::CMD_LETTER
                    && !in_final_i;

  // a stalled word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_word))

  // no new word is taken while a letter string is still being sent
  `ASSERT_IMPLIES(a_busy_mid_string, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

  // the empty result is a lone letter-kind word with code zero
  `ASSERT_IMPLIES(a_empty_shape, clk_i, rst_ni, out_valid_i && out_empty_i, empty_ok)

  // an overlong string reports zero
  `ASSERT_IMPLIES(a_long_zero, clk_i, rst_ni, num_ovf, out_number_i == '0 && out_last_i)

  // a letter that is not final produces no result
  `ASSERT_NEXT(a_mid_letter_quiet, clk_i, rst_ni, mid_letter, !$rose(out_valid_i))

endmodule

bind bijective_base26_converter_unit b26_checker u_b26_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .in_final_i     (in_i.final_letter),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_letter_i   (out_o.out_letter),
  .out_empty_i    (out_o.empty_res),
  .out_number_i   (out_o.out_number),
  .out_overflow_i (out_o.overflow),
  .out_last_i     (out_o.last)
);

`default_nettype wire

### tb/sv/b26_conv_checker.sv
// checker: watches both channels, predicts base-26 conversions and compares result words
module b26_conv_checker #(
  parameter int unsigned MAX_LETTERS = b26_pkg::MAX_LETTERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  b26_in_if    in_mon,
  b26_out_if   out_mon,
  output int   mismatch_o,
  output int   pending_o
);
  import b26_pkg::*;

  typedef struct packed {
    logic kind;
    let_t out_letter;
    logic empty_res;
    num_t out_number;
    logic overflow;
    logic last;
  } result_t;

  result_t         expected_q[$];
  num_t            str_value    = '0;
  cnt_t            str_letters  = '0;
  logic            str_too_long = 1'b0;
  int              mismatches   = 0;
  longint unsigned pow26[0:13];
  longint unsigned spell_max;

  initial begin
    pow26[0]  = 1;
    spell_max = 0;
    for (int i = 1; i <= MAX_LETTERS; i++) begin
      pow26[i]  = pow26[i-1] * 26;
      spell_max = spell_max + pow26[i];
    end
  end

  task automatic predict_conversion(input logic cmd, input num_t number, input let_t code,
                                    input logic fin);
    longint unsigned n;
    longint unsigned d;
    int              len;
    logic            sat;
    let_t            c;
    if (cmd == CMD_NUMBER) begin
      n = number;
      if (n == 0) begin
        expected_q.push_back('{KIND_LETTER, let_t'(0), 1'b1, num_t'(0), 1'b0, 1'b1});
      end else begin
        sat = (n > spell_max);
        if (sat) n = spell_max;
        // strip the all-A offsets to find the string length
        len = 0;
        while (len < MAX_LETTERS && n >= pow26[len]) begin
          n = n - pow26[len];
          len++;
        end
        for (int i = len - 1; i >= 0; i--) begin
          d = n / pow26[i];
          if (d > 25) d = 25;
          n = n - d * pow26[i];
          expected_q.push_back('{KIND_LETTER, let_t'(d), 1'b0, num_t'(0), sat, i == 0});
        end
      end
    end else begin
      c = (code > LET_Z) ? LET_Z : code;
      if (str_letters >= MAX_LETTERS) begin
        str_too_long = 1'b1;
      end else begin
        str_value   = num_t'(str_value * 26 + c + 1);
        str_letters = str_letters + 1'b1;
      end
      if (fin) begin
        expected_q.push_back('{KIND_NUMBER, let_t'(0), 1'b0,
                               str_too_long ? num_t'(0) : str_value, str_too_long, 1'b1});
        str_value    = '0;
        str_letters  = '0;
        str_too_long = 1'b0;
      end
    end
  endtask

  function automatic int field_mismatch(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_conversion(in_mon.command, in_mon.number, in_mon.letter, in_mon.final_letter);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: kind %0d letter %0d number %0d last %0d",
                 out_mon.kind, out_mon.out_letter, out_mon.out_number, out_mon.last);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_mismatch("kind", want.kind, out_mon.kind);
          mismatches += field_mismatch("out_letter", want.out_letter, out_mon.out_letter);
          mismatches += field_mismatch("empty_res", want.empty_res, out_mon.empty_res);
          mismatches += field_mismatch("out_number", want.out_number, out_mon.out_number);
          mismatches += field_mismatch("overflow", want.overflow, out_mon.overflow);
          mismatches += field_mismatch("last", want.last, out_mon.last);
        end
      end
      mismatch_o <= mismatches;
      pending_o  <= expected_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// testbench top: clock, reset, word stimulus, result sink and verdict for the base-26 converter
module tb_top;
  import b26_pkg::*;

  localparam num_t SPELL_MAX = 62'd2580398988131886038;

  logic clk_i;
  logic rst_ni;
  bit   idle_on = 1'b1;
  int   mismatch_cnt;
  int   pending_cnt;

  b26_in_if  in_if ();
  b26_out_if out_if ();

  bijective_base26_converter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  b26_conv_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatch_o (mismatch_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // fields the command ignores are filled with noise
  task automatic send_word(input logic cmd, input num_t num, input let_t code, input logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.number       <= (cmd == CMD_NUMBER) ? num : num_t'({$urandom, $urandom});
    in_if.letter       <= (cmd == CMD_LETTER) ? code : let_t'($urandom);
    in_if.final_letter <= (cmd == CMD_LETTER) ? fin : 1'($urandom);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // result sink with random stall bursts
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    longint unsigned s;
    longint unsigned p;
    num_t            n;
    let_t            code;
    int              len;
    int              pick;
    int              k;
    int              rand_words;
    rst_ni = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_NUMBER;
    in_if.number       <= '0;
    in_if.letter       <= '0;
    in_if.final_letter <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // number extremes, one- to three-letter boundaries, saturation
    send_word(CMD_NUMBER, num_t'(0), '0, 1'b0);
    send_word(CMD_NUMBER, num_t'(1), '0, 1'b0);
    send_word(CMD_NUMBER, num_t'(26), '0, 1'b0);
    send_word(CMD_NUMBER, num_t'(27), '0, 1'b0);
    send_word(CMD_NUMBER, num_t'(703), '0, 1'b0);
    send_word(CMD_NUMBER, SPELL_MAX, '0, 1'b0);
    send_word(CMD_NUMBER, SPELL_MAX + 1'b1, '0, 1'b0);
    // out-of-range letter code saturates to z
    send_word(CMD_LETTER, '0, let_t'(31), 1'b1);
    // number word in the middle of a string leaves the string alone
    send_word(CMD_LETTER, '0, let_t'(0), 1'b0);
    send_word(CMD_NUMBER, num_t'(52), '0, 1'b0);
    send_word(CMD_LETTER, '0, let_t'(1), 1'b1);
    // one letter too many
    for (int i = 0; i < 14; i++) begin
      send_word(CMD_LETTER, '0, LET_Z, i == 13);
    end

    rand_words = 0;
    while (rand_words < 305) begin
      if ($urandom_range(0, 11) == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (rand_words > 270) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        case ($urandom_range(0, 4))
          0: n = num_t'($urandom_range(0, 800));
          1: begin
            // around the all-z value of k letters
            s = 0;
            p = 1;
            k = $urandom_range(1, 13);
            for (int j = 1; j <= k; j++) begin
              p = p * 26;
              s = s + p;
            end
            n = num_t'(s - 1 + $urandom_range(0, 2));
          end
          2: n = num_t'({$urandom, $urandom});
          3: n = num_t'({$urandom, $urandom}) >> $urandom_range(0, 61);
          default: n = SPELL_MAX - 2 + $urandom_range(0, 4);
        endcase
        send_word(CMD_NUMBER, n, '0, 1'b0);
        rand_words++;
      end else if (pick < 9) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 17) : $urandom_range(1, 13);
        for (int i = 0; i < len; i++) begin
          code = ($urandom_range(0, 7) == 0) ? LET_Z : let_t'($urandom_range(0, 31));
          send_word(CMD_LETTER, '0, code, i == len - 1);
          rand_words++;
          if (i < len - 1 && $urandom_range(0, 19) == 0) begin
            send_word(CMD_NUMBER, num_t'($urandom_range(0, 20000)), '0, 1'b0);
            rand_words++;
          end
        end
      end else begin
        // stray letter word, may close or open a string
        send_word(CMD_LETTER, '0, let_t'($urandom), 1'($urandom));
        rand_words++;
      end
    end
    in_if.valid <= 1'b0;
    idle_on = 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/b26_pkg.sv
rtl/b26_if.sv
rtl/b26_sub_unit.sv
rtl/bijective_base26_converter_unit.sv
rtl/b26_checker.sv
tb/sv/b26_conv_checker.sv
tb/sv/tb_top.sv
